>>> rtl/core/wbfd_pkg.sv
// Shared types, constants and frame codes for the wheel base frame decoder.
`timescale 1ns / 1ps

package wbfd_pkg;

  localparam int FRAME_BYTES_DEFAULT = 8;
  localparam int QUEUE_DEPTH         = 2;
  localparam int HEAD_BYTES          = 7;

  localparam logic [7:0] HEADER_CODE  = 8'h35;
  localparam logic [7:0] TYPE_RIGHT   = 8'h21;
  localparam logic [7:0] TYPE_LEFT    = 8'h11;
  localparam logic [7:0] SUB_COUNT    = 8'h13;
  localparam logic [7:0] TYPE_KNIFE   = 8'h02;
  localparam logic [7:0] SUB_KNIFE    = 8'h32;
  localparam logic [7:0] TYPE_BATTERY = 8'h13;
  localparam logic [7:0] SUB_BATTERY  = 8'h50;
  localparam logic [7:0] PAGE_BATTERY = 8'h01;
  localparam logic [7:0] TYPE_END     = 8'h20;
  localparam logic [7:0] SIDE_LEFT    = 8'h01;
  localparam logic [7:0] SIDE_RIGHT   = 8'h02;
  localparam logic [7:0] SWITCH_ON    = 8'h01;

  localparam logic [15:0] BATTERY_OFFSET = 16'd2350;
  // floor(x / 5) == (x * 0xCCCD) >> 18 for every 16-bit x
  localparam logic [15:0] FIFTH_RECIP    = 16'hCCCD;
  localparam int          FIFTH_SHIFT    = 18;
  localparam logic signed [31:0] COUNT_LIMIT = 32'sd2147482647;

  // frame classes handed from the front to the back
  localparam logic [2:0] KIND_NONE      = 3'd0;
  localparam logic [2:0] KIND_RIGHT     = 3'd1;
  localparam logic [2:0] KIND_LEFT      = 3'd2;
  localparam logic [2:0] KIND_KNIFE     = 3'd3;
  localparam logic [2:0] KIND_BATTERY   = 3'd4;
  localparam logic [2:0] KIND_END_LEFT  = 3'd5;
  localparam logic [2:0] KIND_END_RIGHT = 3'd6;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       batch_last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] right_count;
    logic signed [31:0] left_count;
    logic [13:0]        battery_level;
    logic               left_at_end;
    logic               right_at_end;
    logic               frame_done;
    logic               header_bad;
    logic               knife_done;
    logic               odometry_ready;
    logic               batch_done;
  } result_t;

  // one classified frame or batch end; data holds bytes 3..6 big-endian
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] data;
    logic        frame_done;
    logic        header_bad;
    logic        batch_last;
  } job_t;

endpackage

>>> rtl/core/wheel_base_frame_decoder.sv
// Top level of the wheel base frame decoder: byte framer, job queue, decoder, result queue.
`timescale 1ns / 1ps

// Channel   Handshake           Payload   Beat
// input     push / full         item      one received byte, batch end mark
// result    pop / empty         result    state snapshot for a frame or batch end
//
// One byte is taken every cycle while full is low; the byte that causes a result
// passes through the job queue, then the decoder into the result queue.
// The framer and the decoder each run at one beat a cycle when not stalled,
// parted by a two-entry job queue; a two-entry result queue sits at the output.
// Synchronous reset clears framing, counts, flags and both queues; full and
// empty read high while rst is high. Holding pop low stalls the decoder once
// the result queue fills, and full rises once the job queue behind it fills.
// While full is high every byte waits, even one that ends neither a frame nor
// a batch; such bytes give no result and need no room in either queue.
module wheel_base_frame_decoder #(
  parameter int FRAME_BYTES = wbfd_pkg::FRAME_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH = wbfd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  wbfd_pkg::item_t   item,
  input  logic              pop,
  output logic              empty,
  output wbfd_pkg::result_t result
);

  logic              accept;
  logic              job_push;
  logic              job_full;
  logic              job_empty;
  logic              res_full;
  logic              res_empty;
  logic              go;
  wbfd_pkg::job_t    job_in;
  wbfd_pkg::job_t    job_out;
  wbfd_pkg::result_t res_in;

  // hold off the source while in reset and whenever the job queue is full
  assign full   = rst || job_full;
  assign empty  = rst || res_empty;
  assign accept = push && !full;
  // advance a job whenever the result queue has room
  assign go     = !job_empty && !res_full;

  wbfd_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .job_push (job_push),
    .job      (job_in)
  );

  wbfd_fifo #(
    .WIDTH($bits(wbfd_pkg::job_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (go),
    .rdata (job_out),
    .empty (job_empty)
  );

  wbfd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .job    (job_out),
    .result (res_in)
  );

  wbfd_fifo #(
    .WIDTH($bits(wbfd_pkg::result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (go),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop && !empty),
    .rdata (result),
    .empty (res_empty)
  );

endmodule

>>> rtl/core/wbfd_fifo.sv
// Small first-in first-out queue of packed words.
`timescale 1ns / 1ps

module wbfd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = wbfd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> rtl/core/wbfd_front.sv
// Byte gatherer: frames the byte stream and classifies each completed frame.
`timescale 1ns / 1ps

module wbfd_front #(
  parameter int FRAME_BYTES = wbfd_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  wbfd_pkg::item_t item,
  output logic            job_push,
  output wbfd_pkg::job_t  job
);

  localparam int PW = $clog2(FRAME_BYTES);
  localparam int HB = wbfd_pkg::HEAD_BYTES;

  logic [PW-1:0] pos;
  logic [7:0]    frame_bytes [HB];
  logic [7:0]    cur [HB];
  logic          complete;

  assign complete = (pos == PW'(FRAME_BYTES - 1));
  assign job_push = accept && (complete || item.batch_last);

  // frame view including the byte on the input this cycle
  always_comb begin
    for (int i = 0; i < HB; i++) begin
      cur[i] = (pos == PW'(i)) ? item.rx_byte : frame_bytes[i];
    end
  end

  always_comb begin
    job            = '0;
    job.data       = {cur[3], cur[4], cur[5], cur[6]};
    job.frame_done = complete;
    job.header_bad = complete && (cur[0] != wbfd_pkg::HEADER_CODE);
    job.batch_last = item.batch_last;
    job.kind       = wbfd_pkg::KIND_NONE;
    if (complete && !job.header_bad) begin
      if (cur[1] == wbfd_pkg::TYPE_RIGHT && cur[2] == wbfd_pkg::SUB_COUNT) begin
        job.kind = wbfd_pkg::KIND_RIGHT;
      end else if (cur[1] == wbfd_pkg::TYPE_LEFT && cur[2] == wbfd_pkg::SUB_COUNT) begin
        job.kind = wbfd_pkg::KIND_LEFT;
      end else if (cur[1] == wbfd_pkg::TYPE_KNIFE && cur[2] == wbfd_pkg::SUB_KNIFE) begin
        job.kind = wbfd_pkg::KIND_KNIFE;
      end else if (cur[1] == wbfd_pkg::TYPE_BATTERY && cur[2] == wbfd_pkg::SUB_BATTERY
                   && cur[3] == wbfd_pkg::PAGE_BATTERY) begin
        job.kind = wbfd_pkg::KIND_BATTERY;
      end else if (cur[1] == wbfd_pkg::TYPE_END) begin
        if (cur[3] == wbfd_pkg::SIDE_LEFT) begin
          job.kind = wbfd_pkg::KIND_END_LEFT;
        end else if (cur[3] == wbfd_pkg::SIDE_RIGHT) begin
          job.kind = wbfd_pkg::KIND_END_RIGHT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pos < PW'(HB)) begin
      frame_bytes[pos[2:0]] <= item.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= (complete || item.batch_last) ? '0 : pos + PW'(1);
    end
  end

endmodule

>>> rtl/core/wbfd_back.sv
// Decoder back end: applies classified frames to the held state, forms results.
`timescale 1ns / 1ps

module wbfd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  wbfd_pkg::job_t    job,
  output wbfd_pkg::result_t result
);

  logic signed [31:0] right_value;
  logic signed [31:0] left_value;
  logic [13:0]        battery_value;
  logic               right_fresh;
  logic               left_fresh;
  logic               left_end_flag;
  logic               right_end_flag;

  logic signed [31:0] right_value_next;
  logic signed [31:0] left_value_next;
  logic [13:0]        battery_value_next;
  logic               right_fresh_next;
  logic               left_fresh_next;
  logic               left_end_flag_next;
  logic               right_end_flag_next;
  logic               odo;

  logic signed [31:0] raw_count;
  logic signed [31:0] neg_count;
  logic [15:0]        raw_batt;
  logic [15:0]        batt_diff;
  logic [31:0]        batt_prod;
  logic               switch_on;

  function automatic logic signed [31:0] limit_count(input logic signed [31:0] v);
    if (v > wbfd_pkg::COUNT_LIMIT || v < -wbfd_pkg::COUNT_LIMIT) begin
      return '0;
    end
    return v;
  endfunction

  assign raw_count = signed'(job.data);
  assign neg_count = -raw_count;
  assign raw_batt  = job.data[15:0];
  assign batt_diff = raw_batt - wbfd_pkg::BATTERY_OFFSET;
  assign batt_prod = batt_diff * wbfd_pkg::FIFTH_RECIP;
  assign switch_on = (job.data[23:16] == wbfd_pkg::SWITCH_ON);

  always_comb begin
    right_value_next    = right_value;
    left_value_next     = left_value;
    battery_value_next  = battery_value;
    right_fresh_next    = right_fresh;
    left_fresh_next     = left_fresh;
    left_end_flag_next  = left_end_flag;
    right_end_flag_next = right_end_flag;
    odo                 = 1'b0;
    unique case (job.kind)
      wbfd_pkg::KIND_RIGHT: begin
        right_value_next = limit_count(raw_count);
        right_fresh_next = 1'b1;
      end
      wbfd_pkg::KIND_LEFT: begin
        left_value_next = limit_count(neg_count);
        left_fresh_next = 1'b1;
      end
      wbfd_pkg::KIND_BATTERY: begin
        battery_value_next = (raw_batt > wbfd_pkg::BATTERY_OFFSET)
                             ? batt_prod[wbfd_pkg::FIFTH_SHIFT +: 14] : '0;
      end
      wbfd_pkg::KIND_END_LEFT:  left_end_flag_next  = switch_on;
      wbfd_pkg::KIND_END_RIGHT: right_end_flag_next = switch_on;
      default: ;
    endcase
    // batch-end check runs after any frame finished by the same byte
    if (job.batch_last && right_fresh_next && left_fresh_next) begin
      odo              = 1'b1;
      right_fresh_next = 1'b0;
      left_fresh_next  = 1'b0;
    end
  end

  always_comb begin
    result.right_count    = right_value_next;
    result.left_count     = left_value_next;
    result.battery_level  = battery_value_next;
    result.left_at_end    = left_end_flag_next;
    result.right_at_end   = right_end_flag_next;
    result.frame_done     = job.frame_done;
    result.header_bad     = job.header_bad;
    result.knife_done     = (job.kind == wbfd_pkg::KIND_KNIFE);
    result.odometry_ready = odo;
    result.batch_done     = job.batch_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_value    <= '0;
      left_value     <= '0;
      battery_value  <= '0;
      right_fresh    <= 1'b0;
      left_fresh     <= 1'b0;
      left_end_flag  <= 1'b0;
      right_end_flag <= 1'b0;
    end else if (go) begin
      right_value    <= right_value_next;
      left_value     <= left_value_next;
      battery_value  <= battery_value_next;
      right_fresh    <= right_fresh_next;
      left_fresh     <= left_fresh_next;
      left_end_flag  <= left_end_flag_next;
      right_end_flag <= right_end_flag_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_odo_clears_fresh: assert property (@(posedge clk) disable iff (rst)
    (go && odo) |=> !(right_fresh && left_fresh))
    else $error("fresh flags survived an odometry pulse");
  a_odo_at_batch_end: assert property (@(posedge clk) disable iff (rst)
    (go && result.odometry_ready) |-> result.batch_done)
    else $error("odometry pulse outside a batch end");
  a_knife_good_frame: assert property (@(posedge clk) disable iff (rst)
    (go && result.knife_done) |-> (result.frame_done && !result.header_bad))
    else $error("knife pulse without a good frame");
  a_counts_held: assert property (@(posedge clk) disable iff (rst)
    !go |=> ($stable(right_value) && $stable(left_value)))
    else $error("counts changed with no frame decoded");
`endif

endmodule

>>> bench/tb.sv
// Self-checking bench for the wheel base frame decoder: framed byte batches against a predictor.
`timescale 1ns / 1ps

module tb;
  import wbfd_pkg::*;

  localparam int FRAME_LEN    = FRAME_BYTES_DEFAULT;
  localparam int RANDOM_BYTES = 1500;
  // Cycles without any beat on either side before the run is declared hung.
  localparam int STALL_LIMIT  = 4000;
  // Extra cycles after the drain, to catch stray results.
  localparam int TAIL_CYCLES  = 8;
  localparam int PHASE_BYTES  = 200;

  // Frame shapes for the random stimulus. Noise is a frame of random bytes.
  typedef enum int {
    FK_RIGHT, FK_LEFT, FK_KNIFE, FK_BATTERY, FK_END, FK_BAD_HEADER, FK_NOISE
  } frame_kind_e;

  // Idling phases, selected by how many bytes have gone in so far.
  typedef enum int {PH_STEADY, PH_SENDER_GAPS, PH_RECEIVER_STALLS, PH_BOTH} idle_phase_e;

  logic    clk  = 1'b0;
  logic    rst  = 1'b1;
  logic    push = 1'b0;
  logic    pop  = 1'b0;
  item_t   item = '0;
  logic    full;
  logic    empty;
  result_t result;

  wheel_base_frame_decoder DUT (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction: shadow copy of framing, counts, fresh flags, battery
  // level and end switches, advanced once per accepted byte.
  // ---------------------------------------------------------------------------
  logic [7:0]  frame_buf [FRAME_LEN];
  int          frame_pos   = 0;
  logic [31:0] right_val   = '0;
  logic [31:0] left_val    = '0;
  logic        right_new   = 1'b0;
  logic        left_new    = 1'b0;
  logic [13:0] battery_val = '0;
  logic        left_end    = 1'b0;
  logic        right_end   = 1'b0;

  result_t     pending_snapshots[$];  // decoder state snapshots not yet popped
  item_t       byte_stream[$];        // bytes still to be pushed, oldest first
  int          bytes_total = 0;
  int          bytes_taken = 0;
  int          fail_count  = 0;
  int          idle_cycles = 0;

  // Zero any count whose magnitude lies beyond the limit; the most negative
  // value has magnitude 2^31 and is zeroed too.
  function automatic logic [31:0] clamp_count(input logic [31:0] raw_count);
    logic [31:0] mag;
    mag = raw_count[31] ? (32'd0 - raw_count) : raw_count;
    return (mag > COUNT_LIMIT) ? 32'd0 : raw_count;
  endfunction

  task automatic decode_byte(input item_t beat);
    result_t     snap;
    logic [15:0] raw;
    logic        done;
    logic        bad;
    logic        knife;
    logic        odo;
    done  = 1'b0;
    bad   = 1'b0;
    knife = 1'b0;
    odo   = 1'b0;
    frame_buf[frame_pos] = beat.rx_byte;
    frame_pos++;
    if (frame_pos == FRAME_LEN) begin
      frame_pos = 0;
      done      = 1'b1;
      if (frame_buf[0] != HEADER_CODE) begin
        bad = 1'b1;
      end else if (frame_buf[1] == TYPE_RIGHT && frame_buf[2] == SUB_COUNT) begin
        right_val = clamp_count({frame_buf[3], frame_buf[4], frame_buf[5], frame_buf[6]});
        right_new = 1'b1;
      end else if (frame_buf[1] == TYPE_LEFT && frame_buf[2] == SUB_COUNT) begin
        // left wheel turns the other way: negate before the limit check
        left_val = clamp_count(32'd0 - {frame_buf[3], frame_buf[4], frame_buf[5], frame_buf[6]});
        left_new = 1'b1;
      end else if (frame_buf[1] == TYPE_KNIFE && frame_buf[2] == SUB_KNIFE) begin
        knife = 1'b1;
      end else if (frame_buf[1] == TYPE_BATTERY && frame_buf[2] == SUB_BATTERY &&
                   frame_buf[3] == PAGE_BATTERY) begin
        raw         = {frame_buf[5], frame_buf[6]};
        battery_val = (raw > BATTERY_OFFSET) ? 14'((raw - BATTERY_OFFSET) / 5) : 14'd0;
      end else if (frame_buf[1] == TYPE_END) begin
        if (frame_buf[3] == SIDE_LEFT) begin
          left_end = (frame_buf[4] == SWITCH_ON);
        end else if (frame_buf[3] == SIDE_RIGHT) begin
          right_end = (frame_buf[4] == SWITCH_ON);
        end
      end
    end
    // Batch end: drop any partial frame, then check for a fresh pair of counts.
    if (beat.batch_last) begin
      frame_pos = 0;
      if (right_new && left_new) begin
        odo       = 1'b1;
        right_new = 1'b0;
        left_new  = 1'b0;
      end
    end
    if (done || beat.batch_last) begin
      snap.right_count    = right_val;
      snap.left_count     = left_val;
      snap.battery_level  = battery_val;
      snap.left_at_end    = left_end;
      snap.right_at_end   = right_end;
      snap.frame_done     = done;
      snap.header_bad     = bad;
      snap.knife_done     = knife;
      snap.odometry_ready = odo;
      snap.batch_done     = beat.batch_last;
      pending_snapshots.push_back(snap);
    end
  endtask

  task automatic compare_field(input string name, input logic signed [32:0] want,
                               input logic signed [32:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  // Queue the first 'keep' bytes of a frame; mark the last of them as the batch
  // end when asked, so a short keep gives a partial frame cut off by the batch.
  task automatic queue_frame(input logic [0:FRAME_LEN-1][7:0] fr, input int keep,
                             input logic end_batch);
    item_t beat;
    for (int i = 0; i < keep; i++) begin
      beat.rx_byte    = fr[i];
      beat.batch_last = end_batch && (i == keep - 1);
      byte_stream.push_back(beat);
    end
  endtask

  // Lean on the limit edges, the most negative value and small counts.
  function automatic logic [31:0] pick_count();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return COUNT_LIMIT;                 // largest kept
      2:       return COUNT_LIMIT + 32'd1;         // smallest zeroed
      3:       return 32'h8000_0000;
      4:       return 32'd0 - COUNT_LIMIT;         // most negative kept
      5:       return 32'd0 - COUNT_LIMIT - 32'd1; // first negative zeroed
      6:       return 32'($urandom_range(2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_raw_battery();
    case ($urandom_range(6))
      0:       return BATTERY_OFFSET;
      1:       return BATTERY_OFFSET + 16'd1;
      2:       return BATTERY_OFFSET + 16'($urandom_range(12));
      3:       return 16'hFFFF;
      4:       return 16'($urandom_range(BATTERY_OFFSET));
      default: return 16'($urandom);
    endcase
  endfunction

  // Build one frame of the given shape with random content; slip in a wrong
  // subtype or page now and then so near-miss frames are ignored.
  task automatic queue_random_frame(input frame_kind_e kind, input int keep,
                                    input logic end_batch);
    logic [0:FRAME_LEN-1][7:0] fr;
    for (int i = 0; i < FRAME_LEN; i++) begin
      fr[i] = 8'($urandom);
    end
    fr[0] = HEADER_CODE;
    case (kind)
      FK_RIGHT, FK_LEFT: begin
        fr[1] = (kind == FK_RIGHT) ? TYPE_RIGHT : TYPE_LEFT;
        if ($urandom_range(9) != 0) fr[2] = SUB_COUNT;
        {fr[3], fr[4], fr[5], fr[6]} = pick_count();
      end
      FK_KNIFE: begin
        fr[1] = TYPE_KNIFE;
        if ($urandom_range(9) != 0) fr[2] = SUB_KNIFE;
      end
      FK_BATTERY: begin
        fr[1] = TYPE_BATTERY;
        if ($urandom_range(9) != 0) fr[2] = SUB_BATTERY;
        if ($urandom_range(9) != 0) fr[3] = PAGE_BATTERY;
        {fr[5], fr[6]} = pick_raw_battery();
      end
      FK_END: begin
        fr[1] = TYPE_END;
        case ($urandom_range(4))
          0, 1:    fr[3] = SIDE_LEFT;
          2, 3:    fr[3] = SIDE_RIGHT;
          default: ;
        endcase
        if ($urandom_range(2) != 0) fr[4] = SWITCH_ON;
      end
      FK_BAD_HEADER: begin
        // now and then carry a valid-looking count so that ignoring it is visible
        if ($urandom_range(1) != 0) begin
          fr[1] = TYPE_RIGHT;
          fr[2] = SUB_COUNT;
        end
        fr[0] = 8'($urandom);
        if (fr[0] == HEADER_CODE) fr[0] = ~HEADER_CODE;
      end
      default: begin
        if ($urandom_range(1) != 0) fr[0] = 8'($urandom);
      end
    endcase
    queue_frame(fr, keep, end_batch);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the front of the byte stream, predict on each beat taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    idle_phase_e phase;
    int unsigned gap_pct;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_byte(item);
        void'(byte_stream.pop_front());
        bytes_taken++;
      end
      phase   = idle_phase_e'((bytes_taken / PHASE_BYTES) % 4);
      gap_pct = (phase == PH_SENDER_GAPS) ? 66 : (phase == PH_BOTH) ? 20 : 0;
      // Offer the same byte until it is taken, gaps allowed; only one assignment to push per edge.
      if (byte_stream.size() != 0 && $urandom_range(99) >= gap_pct) begin
        push <= 1'b1;
        item <= byte_stream[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each popped result with the oldest predicted snapshot.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t     want;
    idle_phase_e phase;
    int unsigned stall_pct;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_snapshots.size() == 0) begin
          $error("result popped with none expected");
          fail_count++;
        end else begin
          want = pending_snapshots.pop_front();
          compare_field("right_count", want.right_count, result.right_count);
          compare_field("left_count", want.left_count, result.left_count);
          compare_field("battery_level", want.battery_level, result.battery_level);
          compare_field("left_at_end", want.left_at_end, result.left_at_end);
          compare_field("right_at_end", want.right_at_end, result.right_at_end);
          compare_field("frame_done", want.frame_done, result.frame_done);
          compare_field("header_bad", want.header_bad, result.header_bad);
          compare_field("knife_done", want.knife_done, result.knife_done);
          compare_field("odometry_ready", want.odometry_ready, result.odometry_ready);
          compare_field("batch_done", want.batch_done, result.batch_done);
        end
      end
      phase     = idle_phase_e'((bytes_taken / PHASE_BYTES) % 4);
      stall_pct = (phase == PH_RECEIVER_STALLS) ? 66 : (phase == PH_BOTH) ? 20 : 0;
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: restart the count on any beat, give up after a long silence.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the whole byte stream, release reset, drain and judge.
  // ---------------------------------------------------------------------------
  initial begin
    item_t beat;
    int    frames;
    logic  partial;

    // Directed frames.
    // Right count at the largest magnitude that is kept.
    queue_frame({HEADER_CODE, TYPE_RIGHT, SUB_COUNT, 8'h7F, 8'hFF, 8'hFC, 8'h17, 8'h00},
                FRAME_LEN, 1'b0);
    // Left count most negative: zeroed, yet fresh; the batch end fires odometry.
    queue_frame({HEADER_CODE, TYPE_LEFT, SUB_COUNT, 8'h80, 8'h00, 8'h00, 8'h00, 8'hFF},
                FRAME_LEN, 1'b1);
    queue_frame({HEADER_CODE, TYPE_KNIFE, SUB_KNIFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                FRAME_LEN, 1'b0);
    // Battery at full scale of the raw reading.
    queue_frame({HEADER_CODE, TYPE_BATTERY, SUB_BATTERY, PAGE_BATTERY, 8'h00, 8'hFF, 8'hFF,
                 8'hAA}, FRAME_LEN, 1'b0);
    queue_frame({HEADER_CODE, TYPE_END, 8'h00, SIDE_LEFT, SWITCH_ON, 8'h00, 8'h00, 8'h55},
                FRAME_LEN, 1'b0);
    queue_frame({HEADER_CODE, TYPE_END, 8'h00, SIDE_RIGHT, SWITCH_ON, 8'h00, 8'h00, 8'h55},
                FRAME_LEN, 1'b0);
    // Wrong header on an otherwise good count frame: flag it, change nothing.
    queue_frame({8'hCA, TYPE_RIGHT, SUB_COUNT, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00},
                FRAME_LEN, 1'b1);
    // Partial frame cut short by the batch end: drop it and realign.
    queue_frame({HEADER_CODE, TYPE_RIGHT, SUB_COUNT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                3, 1'b1);

    // Random batches: mostly well-formed frames, some partial, some loose noise.
    bytes_total = byte_stream.size();
    while (byte_stream.size() < bytes_total + RANDOM_BYTES) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 12)) begin
          beat.rx_byte    = 8'($urandom);
          beat.batch_last = ($urandom_range(3) == 0);
          byte_stream.push_back(beat);
        end
      end else begin
        frames  = $urandom_range(0, 3);
        partial = ($urandom_range(3) == 0);
        // Pair both wheels now and then so odometry fires often.
        if ($urandom_range(2) == 0) begin
          if ($urandom_range(1) != 0) begin
            queue_random_frame(FK_RIGHT, FRAME_LEN, 1'b0);
            queue_random_frame(FK_LEFT, FRAME_LEN, frames == 0 && !partial);
          end else begin
            queue_random_frame(FK_LEFT, FRAME_LEN, 1'b0);
            queue_random_frame(FK_RIGHT, FRAME_LEN, frames == 0 && !partial);
          end
        end else if (frames == 0 && !partial) begin
          frames = 1;
        end
        for (int f = 0; f < frames; f++) begin
          queue_random_frame(frame_kind_e'($urandom_range(FK_RIGHT, FK_NOISE)), FRAME_LEN,
                             !partial && f == frames - 1);
        end
        if (partial) begin
          queue_random_frame(frame_kind_e'($urandom_range(FK_RIGHT, FK_NOISE)),
                             $urandom_range(1, FRAME_LEN - 1), 1'b1);
        end
      end
    end
    bytes_total = byte_stream.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Sample on the falling edge, clear of the driver and monitor updates.
    do @(negedge clk);
    while (bytes_taken != bytes_total || pending_snapshots.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
